>>> rtl/swm_pkg.sv
`default_nettype none
package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int WIN_W        = 7;
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
   localparam int WIN_RESET    = 3;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   // register indexes
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [CNT_W-1:0]               count_type;
   typedef logic [IDX_W-1:0]               index_type;

   // update control shared by the delay line and the sorted cells
   typedef struct packed {
      logic      advance;
      logic      full;
      count_type fill;
      count_type k;
   } upd_type;

endpackage
`default_nettype wire

>>> rtl/swm_hist.sv
`default_nettype none
module swm_hist (
   input  wire logic              clock,
   input  wire swm_pkg::upd_type  upd,
   input  wire swm_pkg::sample_type sample,
   output swm_pkg::sample_type    oldest
);

   swm_pkg::sample_type hist_ff [swm_pkg::MAX_WINDOW];
   swm_pkg::sample_type hist_in [swm_pkg::MAX_WINDOW];

   for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_tap
      swm_pkg::count_type pos;
      assign pos = swm_pkg::CNT_W'(i);
      if (i < swm_pkg::MAX_WINDOW - 1) begin : g_mid
         always_comb begin
            hist_in[i] = hist_ff[i];
            if (upd.full) begin
               hist_in[i] = (pos == upd.k - 1'b1) ? sample : hist_ff[i+1];
            end else if (pos == upd.fill) begin
               hist_in[i] = sample;
            end
         end
      end else begin : g_end
         always_comb begin
            hist_in[i] = hist_ff[i];
            if (upd.full) begin
               if (pos == upd.k - 1'b1) hist_in[i] = sample;
            end else if (pos == upd.fill) begin
               hist_in[i] = sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.advance) begin
         hist_ff <= hist_in;
      end
   end

   assign oldest = hist_ff[0];

endmodule
`default_nettype wire

>>> rtl/swm_sort.sv
`default_nettype none
module swm_sort (
   input  wire logic                 clock,
   input  wire swm_pkg::upd_type     upd,
   input  wire swm_pkg::sample_type  sample,
   input  wire swm_pkg::sample_type  oldest,
   input  wire swm_pkg::index_type   mid,
   output swm_pkg::sample_type       median
);

   localparam int N = swm_pkg::MAX_WINDOW;

   swm_pkg::sample_type sort_ff [N];
   swm_pkg::sample_type sort_in [N];
   swm_pkg::sample_type rem     [N];   // list with the oldest word taken out
   logic [N-1:0] le_s;
   logic [N-1:0] match;
   logic [N-1:0] shifted;
   logic [N-1:0] le_r;
   logic [N-1:0] rle;
   swm_pkg::count_type rlen;

   assign rlen = upd.full ? upd.k - 1'b1 : upd.fill;

   for (genvar i = 0; i < N; i++) begin : g_cell
      localparam logic [N-1:0] LOW = {N{1'b1}} >> (N - 1 - i);
      swm_pkg::count_type pos;
      assign pos      = swm_pkg::CNT_W'(i);
      assign le_s[i]  = sort_ff[i] <= sample;
      assign match[i] = (pos < upd.k) && (sort_ff[i] == oldest);
      // removal point lies at or below this cell
      assign shifted[i] = upd.full && ((match & LOW) != '0);

      if (i < N - 1) begin : g_up
         assign rem[i]  = shifted[i] ? sort_ff[i+1] : sort_ff[i];
         assign le_r[i] = shifted[i] ? le_s[i+1] : le_s[i];
      end else begin : g_top
         assign rem[i]  = sort_ff[i];
         assign le_r[i] = le_s[i];
      end

      assign rle[i] = (pos < rlen) && le_r[i];

      if (i == 0) begin : g_first
         assign sort_in[i] = rle[i] ? rem[i] : sample;
      end else begin : g_rest
         always_comb begin
            if (rle[i]) begin
               sort_in[i] = rem[i];
            end else if (rle[i-1]) begin
               sort_in[i] = sample;
            end else begin
               sort_in[i] = rem[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.advance) begin
         sort_ff <= sort_in;
      end
   end

   assign median = sort_in[mid];

endmodule
`default_nettype wire

>>> rtl/sliding_window_median.sv
// Path from an accepted req word to its rsp word: input register, then result register.
// Throughput: one sample per cycle if rsp flows; all sorted cells update at once in one pass.
// A result register decouples rsp backpressure; req stalls only while it is full and held.
// Reset (synchronous, active high): clears handshake state and fill count, window_size = 3.
// Delay line and sorted cells are not reset; only entries below the fill count are used.
`default_nettype none
module sliding_window_median (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [swm_pkg::SAMPLE_WIDTH-1:0]  req_tdata,   // [31:0] sample
   input  wire logic                              req_tlast,   // last_sample
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [swm_pkg::SAMPLE_WIDTH-1:0]       rsp_tdata,   // [31:0] median
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [swm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [swm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   // ---------------- configuration ----------------
   logic [swm_pkg::WIN_W-1:0] win_ff, win_in;
   logic                      csr_wr;
   logic                      win_sel;

   assign csr_pready = 1'b1;
   assign win_sel    = csr_paddr[swm_pkg::CSR_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && win_sel;

   always_comb begin
      win_in = win_ff;
      if (csr_wr) win_in = csr_pwdata[swm_pkg::WIN_W-1:0];
   end

   assign csr_prdata = win_sel
      ? {{(swm_pkg::CSR_DATA_W - swm_pkg::WIN_W){1'b0}}, win_ff} : '0;

   // effective window length: zero acts as one, saturate at the cell count
   swm_pkg::count_type k;
   always_comb begin
      priority if (win_ff == '0) begin
         k = swm_pkg::CNT_W'(1);
      end else if (int'(win_ff) > swm_pkg::MAX_WINDOW) begin
         k = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
      end else begin
         k = swm_pkg::CNT_W'(win_ff);
      end
   end

   // lower median sits at (k-1)/2 in the sorted cells
   swm_pkg::count_type km1;
   swm_pkg::index_type mid;
   assign km1 = k - 1'b1;
   assign mid = swm_pkg::IDX_W'(km1 >> 1);

   // ---------------- input register ----------------
   logic                in_valid_ff, in_valid_in;
   swm_pkg::sample_type in_sample_ff, in_sample_in;
   logic                in_last_ff, in_last_in;
   logic                advance;
   logic                req_take;

   logic                out_valid_ff, out_valid_in;
   swm_pkg::sample_type out_median_ff, out_median_in;

   // item in the input register moves on when the result slot is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      in_last_in   = in_last_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = swm_pkg::sample_type'(req_tdata);
         in_last_in   = req_tlast;
      end
   end

   // ---------------- window bookkeeping ----------------
   swm_pkg::count_type fill_ff, fill_in;
   swm_pkg::count_type fill_eff;
   swm_pkg::count_type fill_next;
   logic               full;
   logic               produce;
   swm_pkg::upd_type   upd;
   swm_pkg::sample_type oldest;
   swm_pkg::sample_type median;

   assign fill_eff  = (fill_ff > k) ? '0 : fill_ff;
   assign full      = fill_eff == k;
   assign fill_next = full ? k : fill_eff + 1'b1;
   assign produce   = fill_next == k;

   assign upd.advance = advance;
   assign upd.full    = full;
   assign upd.fill    = fill_eff;
   assign upd.k       = k;

   always_comb begin
      fill_in = fill_ff;
      if (advance) fill_in = in_last_ff ? '0 : fill_next;
      // a window_size write restarts the window
      if (csr_wr) fill_in = '0;
   end

   swm_hist u_hist (
      .clock  (clock),
      .upd    (upd),
      .sample (in_sample_ff),
      .oldest (oldest)
   );

   swm_sort u_sort (
      .clock  (clock),
      .upd    (upd),
      .sample (in_sample_ff),
      .oldest (oldest),
      .mid    (mid),
      .median (median)
   );

   // ---------------- result register ----------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_median_in = out_median_ff;
      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;
      if (advance && produce) begin
         out_valid_in  = 1'b1;
         out_median_in = median;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_median_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= swm_pkg::WIN_W'(swm_pkg::WIN_RESET);
         fill_ff      <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff  <= in_sample_in;
      in_last_ff    <= in_last_in;
      out_median_ff <= out_median_in;
   end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import swm_pkg::*;

   // run limit in clock cycles, far above the slowest passing run
   localparam int CYCLE_LIMIT = 400_000;

   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;
   localparam sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;

   // CSR map: one register per 4 bytes; index 1 is unmapped and must be ignored
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE   = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR  = {REG_SPARE, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;

   // input stream
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_WIDTH-1:0] req_tdata  = '0;   // [31:0] sample
   logic                    req_tlast  = 1'b0; // last_sample

   // result stream
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [SAMPLE_WIDTH-1:0] rsp_tdata;         // [31:0] median

   // configuration
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // traffic shaping, set per test
   int idle_pct  = 0;   // chance (of 100) that the sender idles a cycle
   int stall_pct = 0;   // chance (of 100) that the receiver stalls a cycle
   int rsp_hold  = 0;   // cycles left of a forced receiver hold-off

   int fail_count  = 0;
   int cycle_count = 0;

   // predictor state: window length register, delay line, window in order
   logic [WIN_W-1:0] window_reg = WIN_W'(WIN_RESET);
   sample_type       delay_line[$];
   sample_type       ordered[$];
   sample_type       expected_medians[$];

   sliding_window_median u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // window length in force: zero acts as 1, anything past MAX_WINDOW saturates
   function automatic int window_span(input logic [WIN_W-1:0] w);
      if (w == 0)
         return 1;
      if (w > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(w);
   endfunction

   // one accepted sample: slide the window, keep it sorted, queue the median
   function automatic void median_step(input sample_type value, input logic last);
      int         k;
      int         pos;
      logic       found;
      sample_type oldest;
      k = window_span(window_reg);
      if (delay_line.size() == k) begin
         // full: the oldest leaves, and only one copy of its value goes
         oldest = delay_line.pop_front();
         found  = 1'b0;
         for (int i = 0; i < ordered.size(); i++) begin
            if (!found && ordered[i] == oldest) begin
               ordered.delete(i);
               found = 1'b1;
            end
         end
      end
      delay_line.push_back(value);
      pos = ordered.size();
      while (pos > 0 && value < ordered[pos-1])
         pos--;
      ordered.insert(pos, value);
      // lower median for even windows
      if (delay_line.size() == k)
         expected_medians.push_back(ordered[(k + 1) / 2 - 1]);
      // end of sequence: the next sample opens a fresh window
      if (last) begin
         delay_line.delete();
         ordered.delete();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, before the
   // nonblocking updates of that edge land, so order within the step
   // does not matter. Sample words feed the predictor before results are
   // checked.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      sample_type want;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE) begin
                  // new window length restarts the window empty
                  window_reg = csr_pwdata[WIN_W-1:0];
                  delay_line.delete();
                  ordered.delete();
               end
            end else if (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE) begin
               if (csr_prdata !== CSR_DATA_W'(window_reg)) begin
                  $display("%0t: window_size read: expected %0d, actual %0d",
                           $time, window_reg, csr_prdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            median_step(sample_type'(req_tdata), req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_medians.size() == 0) begin
               $display("%0t: unexpected median word: expected none, actual %0d",
                        $time, $signed(rsp_tdata));
               fail_count++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: median mismatch: expected %0d, actual %0d",
                           $time, want, $signed(rsp_tdata));
                  fail_count++;
               end
            end
         end
      end
   end

   // receiver: random stalls, or a forced hold-off counted down here
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. Every task is entered and left just after a rising edge.
   // ---------------------------------------------------------------------

   // offer one sample word, hold it until taken, then maybe idle a while
   task automatic send_word(input sample_type value, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();
         req_tlast  <= 1'($urandom_range(1));
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // stop sending and wait for every outstanding median; the first edge
   // lets the monitor take in the word accepted last
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_medians.size() != 0);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      // setup phase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      // access phase
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // idle cycle before the next transfer
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // register writes only with the block idle; a sample that gives no
   // median may still be in flight, so allow its latency to pass too.
   // Upper data bits are junk and must be dropped by the register.
   task automatic write_window(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [WIN_W-1:0] w);
      logic [CSR_DATA_W-1:0] data;
      wait_drained();
      repeat (4) @(posedge clock);
      data = $urandom();
      data[WIN_W-1:0] = w;
      csr_access(1'b1, addr, data);
      csr_access(1'b0, WINDOW_ADDR, '0);
   endtask

   // mix of extremes, small values (many duplicates) and full-range values
   function automatic sample_type rand_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2, 3:    return sample_type'($signed($urandom_range(8)) - 4);
         default: return sample_type'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // window length out of reset is 3; last word both with a full and a
   // part-filled window
   task automatic test_default_window();
      csr_access(1'b0, WINDOW_ADDR, '0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(SAMPLE_MAX, 1'b0);
      send_word(0, 1'b0);
      send_word(-1, 1'b0);
      send_word(1, 1'b1);
      send_word(5, 1'b0);
      send_word(6, 1'b1);     // window never fills: no median
   endtask

   // zero length acts as 1, lower median for even lengths, duplicate values
   task automatic test_window_lengths();
      write_window(WINDOW_ADDR, 7'd0);
      send_word(SAMPLE_MIN, 1'b0);
      send_word(SAMPLE_MAX, 1'b1);
      write_window(WINDOW_ADDR, 7'd2);
      send_word(10, 1'b0);
      send_word(20, 1'b0);
      send_word(20, 1'b0);    // only one 20 may leave next
      send_word(-5, 1'b0);
      write_window(WINDOW_ADDR, 7'd4);
      send_word(7, 1'b0);
      send_word(7, 1'b0);
      send_word(-7, 1'b0);
      send_word(7, 1'b0);
      send_word(-7, 1'b0);
   endtask

   // a write to an unmapped index changes nothing, window keeps its fill
   task automatic test_spare_address();
      write_window(SPARE_ADDR, 7'd1);
      send_word(9, 1'b0);
      send_word(-9, 1'b0);
   endtask

   // receiver holds off long enough that the block backs up into req,
   // then the sender pauses until everything has come out
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      write_window(WINDOW_ADDR, 7'd1);
      rsp_hold <= 300;
      for (int i = 0; i < 40; i++)
         send_word(rand_sample(), $urandom_range(7) == 0);
      wait_drained();
      for (int i = 0; i < 10; i++)
         send_word(rand_sample(), 1'b0);
   endtask

   // mostly sequences long enough to fill the window, some cut short
   task automatic run_segment(input logic [WIN_W-1:0] w, input int n_words);
      int k;
      int sent;
      int run_len;
      write_window(WINDOW_ADDR, w);
      k    = window_span(w);
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(9) == 0)
            run_len = $urandom_range(k);
         else
            run_len = k + $urandom_range(2 * k + 8);
         if (run_len == 0)
            run_len = 1;
         for (int i = 0; i < run_len && sent < n_words; i++) begin
            send_word(rand_sample(), i == run_len - 1);
            sent++;
         end
      end
   endtask

   // four traffic modes: free flow, sender idle, receiver stalls, both
   task automatic test_random_traffic();
      int               idle_mode[4];
      int               stall_mode[4];
      logic [WIN_W-1:0] wins[12];
      idle_mode  = '{0, 56, 0, 20};
      stall_mode = '{0, 0, 56, 20};
      wins = '{7'd2, 7'd64, 7'd5, 7'd1, 7'd16, 7'd127,
               7'd0, 7'd9, 7'd3, 7'd64, 7'd4, 7'd33};
      for (int m = 0; m < 4; m++) begin
         idle_pct  = idle_mode[m];
         stall_pct = stall_mode[m];
         for (int j = 0; j < 3; j++)
            run_segment(wins[m * 3 + j], 150);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_window();
      test_window_lengths();
      test_spare_address();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_medians.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/swm_pkg.sv
rtl/swm_hist.sv
rtl/swm_sort.sv
rtl/sliding_window_median.sv
tb/tb_top.sv
